[src/sip_tcp_stream_deframer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the SIP over TCP stream deframer
// Shared helpers that wrap a concurrent assertion with clock and reset.
// ----------------------------------------------------------------------------
`ifndef SIP_TCP_STREAM_DEFRAMER_UNIT_DEFINES_SVH
`define SIP_TCP_STREAM_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIPDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sipdf_pkg.sv]
// ----------------------------------------------------------------------------
// sipdf_pkg
// Types, constants and helper functions of the SIP over TCP stream deframer.
// ----------------------------------------------------------------------------
package sipdf_pkg;

    // Width of the length, body and message counters.
    localparam int COUNT_BITS = 24;
    // Width of the message size limit register.
    localparam int CFG_W      = 24;
    // Width used to compare the message counter with the limit.
    localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    // Width of the decimal accumulator before saturation.
    localparam int ACC_W      = COUNT_BITS + 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};
    localparam logic [CFG_W-1:0]      MAX_MSG_RESET = CFG_W'(10 * 1024 * 1024);

    // Stream byte widths.
    localparam int DATA_W = 8;
    localparam int USER_W = 8;

    // Characters of interest.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LOW_L = 8'h6c;

    // Header name match positions.
    localparam logic [3:0] POS_CL = 4'd14;
    localparam logic [3:0] POS_L  = 4'd15;

    // Minimum line lengths for a length line to count.
    localparam logic [4:0] MIN_CL_LINE = 5'd16;
    localparam logic [4:0] MIN_L_LINE  = 5'd3;
    localparam logic [4:0] LINE_LEN_MAX = 5'd31;

    // Message phase.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY
    } phase_t;

    // Progress through the CR LF CR LF header terminator.
    typedef enum logic [1:0] {
        CRLF_NONE,
        CRLF_CR,
        CRLF_CRLF,
        CRLF_CRLFCR
    } crlf_t;

    // Parse stage of the current header line.
    typedef enum logic [2:0] {
        ST_NAME,
        ST_SKIP,
        ST_WS,
        ST_SIGN,
        ST_DIGITS,
        ST_DONE,
        ST_BAD
    } vstage_t;

    // Message verdict carried on the last byte.
    typedef enum logic [1:0] {
        V_DELIVER,
        V_DROP,
        V_OVERFLOW
    } verdict_t;

    // Parse state of the current header line and the captured length.
    typedef struct packed {
        logic [3:0]            match_pos;
        logic [4:0]            line_len;
        vstage_t               vstage;
        logic                  vneg;
        logic [COUNT_BITS-1:0] lval;
    } line_t;

    // One result item.
    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              first;
        logic              last;
        verdict_t          verdict;
    } res_t;

    // Lower-case spelling of the header name, one character per position.
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[src/sipdf_in_stage.sv]
// ----------------------------------------------------------------------------
// sipdf_in_stage
// Input register: holds one accepted stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module sipdf_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sipdf_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic                        advance,
    output logic                        fire,
    output logic [sipdf_pkg::DATA_W-1:0] in_byte
);
    import sipdf_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [DATA_W-1:0] in_byte_reg;
    logic              accept;

    // The held byte moves on whenever the result side can take it.
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = in_byte_reg;

    // Occupancy of the input register.
    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload capture on every accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

endmodule

[src/sipdf_core.sv]
// ----------------------------------------------------------------------------
// sipdf_core
// Framing state and the single-pass update for one stream byte.
// ----------------------------------------------------------------------------
module sipdf_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sipdf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          fire,
    input  logic [sipdf_pkg::DATA_W-1:0]  in_byte,
    output logic                          res_valid,
    output sipdf_pkg::res_t               res
);
    import sipdf_pkg::*;

    // Framing state.
    logic [CFG_W-1:0]      max_reg;
    phase_t                phase_reg,    phase_next;
    logic                  idle_cr_reg,  idle_cr_next;
    crlf_t                 crlf_reg,     crlf_next;
    line_t                 line_reg,     line_next;
    logic                  found_reg,    found_next;
    logic [COUNT_BITS-1:0] body_reg,     body_next;
    logic [COUNT_BITS-1:0] cnt_reg,      cnt_next;

    logic                  hdr_end;
    logic                  eligible;
    logic                  has_value;
    logic                  minus_one;

    assign cfg_ready = 1'b1;

    // Decimal accumulate with saturation at the counter maximum.
    function automatic logic [COUNT_BITS-1:0] accumulate(
        input logic [COUNT_BITS-1:0] lval,
        input logic [7:0]            c
    );
        logic [ACC_W-1:0] v;
        v = (ACC_W'(lval) << 3) + (ACC_W'(lval) << 1) + ACC_W'(c[3:0]);
        return (|v[ACC_W-1:COUNT_BITS]) ? COUNT_MAX : v[COUNT_BITS-1:0];
    endfunction

    // Line length counts up and sticks at its maximum.
    function automatic logic [4:0] bump_len(input logic [4:0] len);
        return (len != LINE_LEN_MAX) ? len + 5'd1 : len;
    endfunction

    // Feed one line content byte into the line parser.
    function automatic line_t feed(
        input line_t      s,
        input logic       found,
        input logic [7:0] c
    );
        line_t      r;
        logic [7:0] low;
        logic       is_dig;
        logic       is_ws;
        logic       ws_stage;
        r        = s;
        low      = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
        is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        ws_stage = 1'b0;
        r.line_len = bump_len(s.line_len);
        if (!found)
        begin
            unique case (s.vstage)
                ST_NAME:
                begin
                    if (s.match_pos == 4'd0 && low == CH_LOW_L)
                    begin
                        r.match_pos = POS_L;
                        r.vstage    = ST_SKIP;
                    end
                    else if (s.match_pos < POS_CL && low == name_char(s.match_pos))
                    begin
                        r.match_pos = s.match_pos + 4'd1;
                        if (s.match_pos == POS_CL - 4'd1)
                        begin
                            r.vstage = ST_SKIP;
                        end
                    end
                    else
                    begin
                        r.vstage = ST_BAD;
                    end
                end
                ST_SKIP:
                begin
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                        r.vstage = ST_SKIP;
                    end
                    else if (c == CH_COLON)
                    begin
                        r.vstage = ST_WS;
                    end
                    else
                    begin
                        ws_stage = 1'b1;
                    end
                end
                ST_WS:
                begin
                    ws_stage = 1'b1;
                end
                ST_SIGN:
                begin
                    if (is_dig)
                    begin
                        r.lval   = accumulate(s.lval, c);
                        r.vstage = ST_DIGITS;
                    end
                    else
                    begin
                        r.vstage = ST_BAD;
                    end
                end
                ST_DIGITS:
                begin
                    if (is_dig)
                    begin
                        r.lval = accumulate(s.lval, c);
                    end
                    else
                    begin
                        r.vstage = ST_DONE;
                    end
                end
                default:
                begin
                    r.vstage = s.vstage;
                end
            endcase

            // White space before the value, then a sign or the first digit.
            if (ws_stage)
            begin
                if (is_ws)
                begin
                    r.vstage = ST_WS;
                end
                else if (c == CH_PLUS)
                begin
                    r.vstage = ST_SIGN;
                end
                else if (c == CH_MINUS)
                begin
                    r.vneg   = 1'b1;
                    r.vstage = ST_SIGN;
                end
                else if (is_dig)
                begin
                    r.lval   = accumulate(s.lval, c);
                    r.vstage = ST_DIGITS;
                end
                else
                begin
                    r.vstage = ST_BAD;
                end
            end
        end
        return r;
    endfunction

    // A CR that turns out to be line content; it never adds a digit.
    function automatic line_t feed_cr(input line_t s, input logic found);
        line_t r;
        r          = s;
        r.line_len = bump_len(s.line_len);
        if (!found)
        begin
            unique case (s.vstage)
                ST_NAME:   r.vstage = ST_BAD;
                ST_SKIP:   r.vstage = ST_WS;
                ST_WS:     r.vstage = ST_WS;
                ST_SIGN:   r.vstage = ST_BAD;
                ST_DIGITS: r.vstage = ST_DONE;
                default:   r.vstage = s.vstage;
            endcase
        end
        return r;
    endfunction

    // Start a new line; the captured value survives once a length is found.
    function automatic line_t clear_line(input line_t s, input logic found);
        line_t r;
        r           = s;
        r.match_pos = 4'd0;
        r.line_len  = 5'd0;
        r.vstage    = ST_NAME;
        if (!found)
        begin
            r.vneg = 1'b0;
            r.lval = '0;
        end
        return r;
    endfunction

    // Line end checks.
    assign eligible  = (line_reg.match_pos == POS_CL && line_reg.line_len >= MIN_CL_LINE) ||
                       (line_reg.match_pos == POS_L && line_reg.line_len >= MIN_L_LINE);
    assign has_value = (line_reg.vstage == ST_DIGITS) || (line_reg.vstage == ST_DONE);
    assign minus_one = line_reg.vneg && (line_reg.lval == COUNT_BITS'(1));

    // Next state and result for the byte in the input register.
    always_comb
    begin
        logic go;
        logic is_hdr;
        phase_next   = phase_reg;
        idle_cr_next = idle_cr_reg;
        crlf_next    = crlf_reg;
        line_next    = line_reg;
        found_next   = found_reg;
        body_next    = body_reg;
        cnt_next     = cnt_reg;
        hdr_end      = 1'b0;
        go           = 1'b1;
        is_hdr       = 1'b0;
        res.out_byte = in_byte;
        res.first    = 1'b0;
        res.last     = 1'b0;
        res.verdict  = V_DELIVER;

        // Idle: drop CRs and an LF that follows a CR, anything else opens a message.
        if (phase_reg != PH_HEADER && phase_reg != PH_BODY)
        begin
            if (idle_cr_reg)
            begin
                if (in_byte == CH_LF)
                begin
                    idle_cr_next = 1'b0;
                    go           = 1'b0;
                end
                else if (in_byte == CH_CR)
                begin
                    go = 1'b0;
                end
                else
                begin
                    idle_cr_next = 1'b0;
                end
            end
            else if (in_byte == CH_CR)
            begin
                idle_cr_next = 1'b1;
                go           = 1'b0;
            end
            if (go)
            begin
                crlf_next  = CRLF_NONE;
                found_next = 1'b0;
                line_next  = clear_line(line_reg, 1'b0);
                body_next  = '0;
                cnt_next   = '0;
                is_hdr     = 1'b1;
                res.first  = 1'b1;
            end
        end
        else
        begin
            is_hdr = (phase_reg == PH_HEADER);
        end

        if (go)
        begin
            if (is_hdr)
            begin
                phase_next = PH_HEADER;
                // Header byte: track the terminator and feed line content.
                if (in_byte == CH_CR)
                begin
                    unique case (crlf_next)
                        CRLF_CR, CRLF_CRLFCR:
                        begin
                            line_next = feed_cr(line_next, found_next);
                            crlf_next = CRLF_CR;
                        end
                        CRLF_CRLF: crlf_next = CRLF_CRLFCR;
                        default:   crlf_next = CRLF_CR;
                    endcase
                end
                else if (in_byte == CH_LF)
                begin
                    if (crlf_next == CRLF_CR)
                    begin
                        // End of a header line.
                        if (!found_next && eligible && has_value && !minus_one)
                        begin
                            found_next = 1'b1;
                        end
                        line_next = clear_line(line_next, found_next);
                        crlf_next = CRLF_CRLF;
                    end
                    else if (crlf_next == CRLF_CRLFCR)
                    begin
                        hdr_end = 1'b1;
                    end
                    else
                    begin
                        line_next = feed(line_next, found_next, in_byte);
                        crlf_next = CRLF_NONE;
                    end
                end
                else
                begin
                    if (crlf_next == CRLF_CR || crlf_next == CRLF_CRLFCR)
                    begin
                        line_next = feed_cr(line_next, found_next);
                    end
                    line_next = feed(line_next, found_next, in_byte);
                    crlf_next = CRLF_NONE;
                end

                // Header complete: deliver, go to the body, or drop.
                if (hdr_end)
                begin
                    if (found_next && !(line_next.vneg && line_next.lval != '0))
                    begin
                        if (line_next.lval == '0)
                        begin
                            res.last = 1'b1;
                        end
                        else
                        begin
                            body_next  = line_next.lval;
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        res.last    = 1'b1;
                        res.verdict = V_DROP;
                    end
                end
            end
            else
            begin
                // Body byte.
                if (body_next != '0)
                begin
                    body_next = body_next - COUNT_BITS'(1);
                end
                if (body_next == '0)
                begin
                    res.last = 1'b1;
                end
            end

            // Size limit.
            if (!res.last && CMP_W'(cnt_next) >= CMP_W'(max_reg))
            begin
                res.last    = 1'b1;
                res.verdict = V_OVERFLOW;
            end
            if (cnt_next != COUNT_MAX)
            begin
                cnt_next = cnt_next + COUNT_BITS'(1);
            end

            // Message end returns to idle with clean state.
            if (res.last)
            begin
                crlf_next  = CRLF_NONE;
                found_next = 1'b0;
                line_next  = clear_line(line_next, 1'b0);
                body_next  = '0;
                cnt_next   = '0;
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            phase_next = PH_IDLE;
        end
        res_valid = fire && go;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_MSG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reg <= cfg_data;
        end
    end

    // State update on each byte taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            idle_cr_reg <= 1'b0;
            crlf_reg    <= CRLF_NONE;
            line_reg    <= '{match_pos: 4'd0, line_len: 5'd0, vstage: ST_NAME,
                             vneg: 1'b0, lval: '0};
            found_reg   <= 1'b0;
            body_reg    <= '0;
            cnt_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            idle_cr_reg <= idle_cr_next;
            crlf_reg    <= crlf_next;
            line_reg    <= line_next;
            found_reg   <= found_next;
            body_reg    <= body_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

[src/sipdf_out_stage.sv]
// ----------------------------------------------------------------------------
// sipdf_out_stage
// Result register: presents one result transaction on the master side.
// ----------------------------------------------------------------------------
module sipdf_out_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          res_valid,
    input  sipdf_pkg::res_t               res,
    output logic                          advance,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sipdf_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic [sipdf_pkg::USER_W-1:0]  m_axis_tuser
);
    import sipdf_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;

    // The register may load when empty or when its content leaves now.
    assign advance = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire)
        begin
            out_reg <= res;
        end
    end

    // Port packing: tuser holds first_of_message then verdict.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.out_byte;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = {{(USER_W - 3){1'b0}}, out_reg.verdict, out_reg.first};

endmodule

[src/sip_tcp_stream_deframer_unit.sv]
// ----------------------------------------------------------------------------
// sip_tcp_stream_deframer_unit
// Splits a text message byte stream into framed messages with a verdict.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata[7:0] data_byte
//  m_axis    out        tdata[7:0] out_byte, tlast last_of_message,
//                       tuser[0] first_of_message, tuser[2:1] verdict
//  cfg       in         cfg_data[23:0] max_message_bytes
//
// One byte per cycle sustained while the master side takes results. An
// accepted byte sits in the input register while the parse runs, and its
// result is then loaded into the result register and presented from it. The parse is
// a single pass of logic between those two registers. Reset is asynchronous
// and active low and needs no clearing pass. A stall on the master side holds
// the result and fills the input register before tready falls on the slave side.
// ----------------------------------------------------------------------------
module sip_tcp_stream_deframer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Fields from bit 0: data_byte[7:0].
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sipdf_pkg::DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: out_byte[7:0].
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sipdf_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    // Fields from bit 0: first_of_message[0], verdict[2:1], zero fill[7:3].
    output logic [sipdf_pkg::USER_W-1:0]  m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sipdf_pkg::CFG_W-1:0]   cfg_data
);
    import sipdf_pkg::*;

    logic              advance;
    logic              fire;
    logic [DATA_W-1:0] in_byte;
    logic              res_valid;
    res_t              res;

    // Input register.
    sipdf_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .fire          (fire),
        .in_byte       (in_byte)
    );

    // Framing state and per-byte update.
    sipdf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    sipdf_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .res_valid     (res_valid),
        .res           (res),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[src/sipdf_checker.sv]
// ----------------------------------------------------------------------------
// sipdf_checker
// Port-level checks of message framing on the deframer's result stream.
// ----------------------------------------------------------------------------
`include "sip_tcp_stream_deframer_unit_defines.svh"

module sipdf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sipdf_pkg::DATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic [sipdf_pkg::USER_W-1:0]  m_axis_tuser
);
    import sipdf_pkg::*;

    logic     out_xfer;
    logic     in_xfer;
    logic     between_reg;
    logic     between_next;
    verdict_t verdict;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign verdict  = verdict_t'(m_axis_tuser[2:1]);

    // Tracks whether the next result transaction opens a new message.
    always_comb
    begin
        if (out_xfer)
        begin
            between_next = m_axis_tlast;
        end
        else
        begin
            between_next = between_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            between_reg <= 1'b1;
        end
        else
        begin
            between_reg <= between_next;
        end
    end

    // A message opens exactly after the previous one closed.
    `SIPDF_ASSERT_SAME(a_first_follows_last, clk, rst_n, out_xfer,
        m_axis_tuser[0] == between_reg, "first_of_message out of step with tlast")

    // The verdict is zero on every byte that does not end a message.
    `SIPDF_ASSERT_SAME(a_verdict_on_last, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
        verdict == V_DELIVER, "nonzero verdict on a byte that is not last")

    // No result shows the unused verdict code or stray user bits.
    `SIPDF_ASSERT_SAME(a_verdict_code, clk, rst_n, m_axis_tvalid,
        m_axis_tuser[2:1] != 2'b11 && m_axis_tuser[USER_W-1:3] == '0,
        "invalid verdict code or user padding")

    // A stalled result transaction holds its contents.
    `SIPDF_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
        && $stable(m_axis_tuser), "result changed while stalled")

    // A result that appears after an empty cycle comes from a byte accepted in
    // the cycle before that empty cycle.
    `SIPDF_ASSERT_NEXT(a_no_invented, clk, rst_n, !m_axis_tvalid,
        !m_axis_tvalid || $past(in_xfer, 2), "result appeared with no byte accepted")

endmodule

bind sip_tcp_stream_deframer_unit sipdf_checker u_sipdf_checker (.*);
